### src/perlin_noise_pixel_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Perlin noise pixel generator
// Immediate-style wrappers around concurrent properties on the block clock.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define PERLIN_NOISE_PIXEL_GENERATOR_CORE_DEFINES_SVH

// expression holds at every edge outside reset
`define PNPG_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define PNPG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

### src/pnpg_pkg.sv
// ----------------------------------------------------------------------------
// Perlin noise pixel generator package
// Shared constants and the transaction type carried from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnpg_pkg;

   localparam int MAX_SIDE    = 4096;
   localparam int TABLE_SIZE  = 256;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] SCALE_RESET = 16'd410;
   localparam logic        REQ_EVAL    = 1'b0;
   localparam logic        REQ_WRITE   = 1'b1;

   typedef struct packed {
      logic        is_wr;
      logic [27:0] sx;
      logic [27:0] sy;
      logic [7:0]  idx;
      logic [7:0]  val;
   } q_item_type;

   typedef struct packed {
      logic push;
      logic full;
   } q_ctl_type;

endpackage

`default_nettype wire

### src/pnpg_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, drops out-of-frame evaluations and scales coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnpg_front
   import pnpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_req_type,
   input  wire logic [11:0] req_pixel_x,
   input  wire logic [11:0] req_pixel_y,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [7:0]  req_entry_value,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        q_full,
   output      q_ctl_type   q_ctl,
   output      q_item_type  q_item
);

   logic        scale_ff;
   logic [15:0] coord_scale_ff;
   logic        f_vld_ff;
   q_item_type  f_item_ff;
   logic        keep_in;
   q_item_type  item_in;

   assign scale_ff = 1'b0;

   always_comb begin
      keep_in = (req_req_type == REQ_WRITE) ||
                ((17'(req_pixel_x) < 17'(MAX_SIDE)) && (17'(req_pixel_y) < 17'(MAX_SIDE)));
      item_in.is_wr = (req_req_type == REQ_WRITE);
      item_in.sx    = 28'(req_pixel_x) * 28'(coord_scale_ff);
      item_in.sy    = 28'(req_pixel_y) * 28'(coord_scale_ff);
      item_in.idx   = req_entry_index;
      item_in.val   = req_entry_value;
   end

   assign req_ready   = !f_vld_ff || !q_full;
   assign q_ctl.push  = f_vld_ff && !q_full;
   assign q_ctl.full  = q_full || scale_ff;
   assign q_item      = f_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_scale_ff <= SCALE_RESET;
         f_vld_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            coord_scale_ff <= csr_wr_data;
         end
         if (req_ready) begin
            f_vld_ff <= req_valid && keep_in;
         end
      end
      if (req_ready) begin
         f_item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### src/pnpg_queue.sv
// ----------------------------------------------------------------------------
// Transaction queue
// Small FIFO that decouples the front end from the noise pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "perlin_noise_pixel_generator_core_defines.svh"

module pnpg_queue
   import pnpg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_ctl_type  q_ctl,
   input  wire q_item_type push_item,
   output      logic       full,
   input  wire logic       pop,
   output      logic       empty,
   output      q_item_type head
);

   q_item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                push;

   assign push  = q_ctl.push;
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `PNPG_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `PNPG_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full || q_ctl.full == 1'b0)
   `PNPG_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, !empty)

endmodule

`default_nettype wire

### src/pnpg_back.sv
// ----------------------------------------------------------------------------
// Noise pipeline
// Seven-stage pipeline: table hashing, quintic fade, gradients and blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnpg_back
   import pnpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire q_item_type  head,
   output      logic        pop,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_pixel_value,
   output      logic signed [15:0] rsp_noise_value
);

   function automatic logic signed [18:0] grad_f(input logic [7:0] hv,
                                                 input logic signed [17:0] gx,
                                                 input logic signed [17:0] gy);
      logic [3:0]         h;
      logic signed [18:0] gu;
      logic signed [18:0] gv;
      h  = hv[3:0];
      gu = (h < 4'd8) ? 19'(gx) : 19'(gy);
      if (h < 4'd4) begin
         gv = 19'(gy);
      end else if (h == 4'd12 || h == 4'd14) begin
         gv = 19'(gx);
      end else begin
         gv = 19'sd0;
      end
      if (h[0]) gu = -gu;
      if (h[1]) gv = -gv;
      return gu + gv;
   endfunction

   logic [7:0] m0 [TABLE_SIZE];
   logic [7:0] m1 [TABLE_SIZE];
   logic [7:0] m2 [TABLE_SIZE];
   logic [7:0] m3 [TABLE_SIZE];
   logic [7:0] m4 [TABLE_SIZE];

   logic en;

   // stage 1
   logic               s1_vld_ff, s1_wr_ff;
   logic [7:0]         s1_idx_ff, s1_val_ff, s1_cy_ff;
   logic [15:0]        s1_fx_ff, s1_fy_ff;
   logic [7:0]         h0a_ff, h0b_ff;
   logic signed [38:0] p1x_ff, p1y_ff;
   logic [7:0]         cx_in, cx1_in;
   logic [15:0]        fx_in, fy_in;
   logic signed [21:0] ax_in, ay_in;

   // stage 2
   logic               s2_vld_ff, s2_wr_ff;
   logic [7:0]         s2_idx_ff, s2_val_ff;
   logic [15:0]        s2_fx_ff, s2_fy_ff;
   logic [7:0]         aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [40:0] p2x_ff, p2y_ff;
   logic [7:0]         a_in, b_in;
   logic signed [23:0] c1x_in, c1y_in;

   // stage 3
   logic               s3_vld_ff, s3_wr_ff;
   logic [15:0]        s3_fx_ff, s3_fy_ff;
   logic [7:0]         haa_ff, hab_ff, hba_ff, hbb_ff;
   logic signed [40:0] p3x_ff, p3y_ff;

   // stage 4
   logic               s4_vld_ff;
   logic signed [18:0] g00_ff, g10_ff, g01_ff, g11_ff;
   logic signed [40:0] p4x_ff, p4y_ff;
   logic signed [17:0] x0_in, x1_in, y0_in, y1_in;

   // stage 5
   logic               s5_vld_ff;
   logic signed [43:0] d0_ff, d1_ff;
   logic signed [18:0] g00_5_ff, g01_5_ff;
   logic signed [23:0] v_ff;
   logic signed [23:0] u_in;

   // stage 6
   logic               s6_vld_ff;
   logic signed [23:0] l0_ff;
   logic signed [47:0] e_ff;
   logic signed [23:0] l0_in, l1_in;

   // stage 7
   logic               s7_vld_ff;
   logic [7:0]         pix_ff;
   logic signed [15:0] nq_ff;
   logic signed [23:0] r_in;
   logic signed [24:0] rp_in;
   logic signed [33:0] num_in;
   logic signed [20:0] rs_in;
   logic [7:0]         pix_in;
   logic signed [15:0] nq_in;

   assign en  = !s7_vld_ff || rsp_ready;
   assign pop = en && !q_empty;

   assign rsp_valid       = s7_vld_ff;
   assign rsp_pixel_value = pix_ff;
   assign rsp_noise_value = nq_ff;

   always_comb begin
      cx_in  = head.sx[19:12];
      cx1_in = cx_in + 8'd1;
      fx_in  = {head.sx[11:0], 4'd0};
      fy_in  = {head.sy[11:0], 4'd0};
      ax_in  = $signed({6'd0, fx_in}) * 22'sd6 - 22'sd983040;
      ay_in  = $signed({6'd0, fy_in}) * 22'sd6 - 22'sd983040;

      a_in   = h0a_ff + s1_cy_ff;
      b_in   = h0b_ff + s1_cy_ff;
      c1x_in = 24'($signed(p1x_ff[38:16])) + 24'sd655360;
      c1y_in = 24'($signed(p1y_ff[38:16])) + 24'sd655360;

      x0_in  = $signed({2'd0, s3_fx_ff});
      y0_in  = $signed({2'd0, s3_fy_ff});
      x1_in  = x0_in - 18'sd65536;
      y1_in  = y0_in - 18'sd65536;

      u_in   = p4x_ff[39:16];

      l0_in  = 24'(g00_5_ff) + 24'(d0_ff[43:16]);
      l1_in  = 24'(g01_5_ff) + 24'(d1_ff[43:16]);

      r_in   = l0_ff + 24'(e_ff[47:16]);
      rp_in  = 25'(r_in) + 25'sd65536;
      num_in = (34'(rp_in) <<< 8) - 34'(rp_in);
      if (num_in < 34'sd0) begin
         pix_in = 8'd0;
      end else if (num_in[33:17] > 17'd255) begin
         pix_in = 8'd255;
      end else begin
         pix_in = num_in[24:17];
      end
      rs_in = r_in[23:3];
      if (rs_in > 21'sd32767) begin
         nq_in = 16'sd32767;
      end else if (rs_in < -21'sd32768) begin
         nq_in = -16'sd32768;
      end else begin
         nq_in = rs_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= pop;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff && !s3_wr_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   // advance payload; each table copy is written in the stage that reads it
   always_ff @(posedge clock) begin
      if (en) begin
         s1_wr_ff  <= head.is_wr;
         s1_idx_ff <= head.idx;
         s1_val_ff <= head.val;
         s1_cy_ff  <= head.sy[19:12];
         s1_fx_ff  <= fx_in;
         s1_fy_ff  <= fy_in;
         h0a_ff    <= m0[cx_in];
         h0b_ff    <= m0[cx1_in];
         p1x_ff    <= ax_in * $signed({1'b0, fx_in});
         p1y_ff    <= ay_in * $signed({1'b0, fy_in});
         if (pop && head.is_wr) begin
            m0[head.idx] <= head.val;
         end

         s2_wr_ff  <= s1_wr_ff;
         s2_idx_ff <= s1_idx_ff;
         s2_val_ff <= s1_val_ff;
         s2_fx_ff  <= s1_fx_ff;
         s2_fy_ff  <= s1_fy_ff;
         aa_ff     <= m1[a_in];
         ab_ff     <= m1[a_in + 8'd1];
         ba_ff     <= m2[b_in];
         bb_ff     <= m2[b_in + 8'd1];
         p2x_ff    <= c1x_in * $signed({1'b0, s1_fx_ff});
         p2y_ff    <= c1y_in * $signed({1'b0, s1_fy_ff});
         if (s1_vld_ff && s1_wr_ff) begin
            m1[s1_idx_ff] <= s1_val_ff;
            m2[s1_idx_ff] <= s1_val_ff;
         end

         s3_wr_ff  <= s2_wr_ff;
         s3_fx_ff  <= s2_fx_ff;
         s3_fy_ff  <= s2_fy_ff;
         haa_ff    <= m3[aa_ff];
         hab_ff    <= m3[ab_ff];
         hba_ff    <= m4[ba_ff];
         hbb_ff    <= m4[bb_ff];
         p3x_ff    <= $signed(p2x_ff[39:16]) * $signed({1'b0, s2_fx_ff});
         p3y_ff    <= $signed(p2y_ff[39:16]) * $signed({1'b0, s2_fy_ff});
         if (s2_vld_ff && s2_wr_ff) begin
            m3[s2_idx_ff] <= s2_val_ff;
            m4[s2_idx_ff] <= s2_val_ff;
         end

         g00_ff    <= grad_f(haa_ff, x0_in, y0_in);
         g10_ff    <= grad_f(hba_ff, x1_in, y0_in);
         g01_ff    <= grad_f(hab_ff, x0_in, y1_in);
         g11_ff    <= grad_f(hbb_ff, x1_in, y1_in);
         p4x_ff    <= $signed(p3x_ff[39:16]) * $signed({1'b0, s3_fx_ff});
         p4y_ff    <= $signed(p3y_ff[39:16]) * $signed({1'b0, s3_fy_ff});

         d0_ff     <= u_in * 20'(g10_ff - g00_ff);
         d1_ff     <= u_in * 20'(g11_ff - g01_ff);
         g00_5_ff  <= g00_ff;
         g01_5_ff  <= g01_ff;
         v_ff      <= p4y_ff[39:16];

         l0_ff     <= l0_in;
         e_ff      <= v_ff * (l1_in - l0_in);

         pix_ff    <= pix_in;
         nq_ff     <= nq_in;
      end
   end

endmodule

`default_nettype wire

### src/perlin_noise_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// Perlin noise pixel generator core
// Improved Perlin noise at z=0, one 8-bit gray pixel per pixel coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries either a hash table write (req_type 1,
//   entry_index/entry_value) or a pixel evaluation (req_type 0, pixel_x/y).
//   Only evaluations produce a transaction on the rsp channel, in order.
//   csr_wr_en/csr_wr_data load coord_scale (Q4.12, reset 410); write it
//   only while the block is idle.
//   Throughput: one transaction per cycle while rsp_ready stays high, set by
//   the fully pipelined noise datapath.
//   A request passes the front register, then the queue, then the 7
//   pipeline stages, the last of which is the output register.
//   The table is replicated in five copies so every lookup gets its own
//   read port; all hash entries must be written before they are read.
//   Reset clears the queue and pipeline valids and restores coord_scale;
//   the table contents are left undefined.
//   When rsp_ready is low with rsp_valid high the pipeline holds; the 4-entry
//   queue keeps the front end accepting until it fills, then req_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module perlin_noise_pixel_generator_core
   import pnpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_req_type,
   input  wire logic [11:0] req_pixel_x,
   input  wire logic [11:0] req_pixel_y,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [7:0]  req_entry_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_pixel_value,
   output      logic signed [15:0] rsp_noise_value,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   q_ctl_type  q_ctl;
   q_item_type q_item;
   q_item_type head;
   logic       q_full;
   logic       q_empty;
   logic       pop;

   pnpg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_req_type    (req_req_type),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_full          (q_full),
      .q_ctl           (q_ctl),
      .q_item          (q_item)
   );

   pnpg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_ctl     (q_ctl),
      .push_item (q_item),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   pnpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

`default_nettype wire

### tb/sv/pnpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perlin noise pixel checker
// Watches the request, response and register ports, predicts each pixel from
// its own copy of the hash table and scale, and compares responses in order.
// ----------------------------------------------------------------------------

module pnpg_checker
   import pnpg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_req_type,
   input  logic [11:0]       req_pixel_x,
   input  logic [11:0]       req_pixel_y,
   input  logic [7:0]        req_entry_index,
   input  logic [7:0]        req_entry_value,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [7:0]        rsp_pixel_value,
   input  logic signed [15:0] rsp_noise_value,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   output int                err_count,
   output int                pending,
   output int                pixels_checked,
   output int                table_writes
);

   typedef struct {
      logic [7:0]         pixel;
      logic signed [15:0] noise;
   } pixel_type;

   logic [7:0]  perm_table [TABLE_SIZE];
   logic [15:0] scale;
   pixel_type   expected_pixels [$];

   function automatic longint fade(longint f);
      longint c;
      c = (((6 * f - 15 * 65536) * f) >>> 16) + 10 * 65536;
      c = (c * f) >>> 16;
      c = (c * f) >>> 16;
      c = (c * f) >>> 16;
      return c;
   endfunction

   function automatic longint blend(longint t, longint a, longint b);
      return a + ((t * (b - a)) >>> 16);
   endfunction

   function automatic longint grad(logic [7:0] hv, longint x, longint y);
      logic [3:0] h;
      longint     u;
      longint     v;
      h = hv[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : 0);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic [7:0] perm(longint i);
      return perm_table[i & (TABLE_SIZE - 1)];
   endfunction

   function automatic pixel_type noise_pixel(logic [11:0] px, logic [11:0] py);
      pixel_type p;
      longint  sx, sy, cx, cy, fx, fy, u, v, a, b, aa, ab, ba, bb, r, nq, num, pix;
      sx = longint'(px) * longint'(scale);
      sy = longint'(py) * longint'(scale);
      cx = (sx >> 12) & 255;
      cy = (sy >> 12) & 255;
      fx = (sx & 12'hFFF) << 4;
      fy = (sy & 12'hFFF) << 4;
      u  = fade(fx);
      v  = fade(fy);
      a  = longint'(perm(cx)) + cy;
      b  = longint'(perm(cx + 1)) + cy;
      aa = perm(a);
      ab = perm(a + 1);
      ba = perm(b);
      bb = perm(b + 1);
      r  = blend(v,
                 blend(u, grad(perm(aa), fx, fy), grad(perm(ba), fx - 65536, fy)),
                 blend(u, grad(perm(ab), fx, fy - 65536),
                       grad(perm(bb), fx - 65536, fy - 65536)));
      nq = r >>> 3;
      if (nq > 32767) nq = 32767;
      if (nq < -32768) nq = -32768;
      num = (r + 65536) * 255;
      if (num < 0) pix = 0;
      else begin
         pix = num >>> 17;
         if (pix > 255) pix = 255;
      end
      p.pixel = pix[7:0];
      p.noise = nq[15:0];
      return p;
   endfunction

   assign pending = expected_pixels.size();

   always @(posedge clock) begin
      pixel_type exp_p;
      if (reset) begin
         scale = SCALE_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) scale = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("checker: unexpected pixel %0d noise %0d",
                           rsp_pixel_value, rsp_noise_value);
            end else begin
               exp_p = expected_pixels.pop_front();
               pixels_checked++;
               if (exp_p.pixel !== rsp_pixel_value || exp_p.noise !== rsp_noise_value) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("checker: pixel exp %0d got %0d, noise exp %0d got %0d",
                              exp_p.pixel, rsp_pixel_value, exp_p.noise, rsp_noise_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_req_type == REQ_WRITE) begin
               perm_table[req_entry_index] = req_entry_value;
               table_writes++;
            end else
               expected_pixels.push_back(noise_pixel(req_pixel_x, req_pixel_y));
         end
      end
   end

   initial begin
      err_count      = 0;
      pixels_checked = 0;
      table_writes   = 0;
      scale          = SCALE_RESET;
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perlin noise pixel generator testbench
// Loads the hash table, runs corner pixels at extreme scales, then random
// pixels and table rewrites under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------

module tb;
   import pnpg_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_req_type;
   logic [11:0]       req_pixel_x;
   logic [11:0]       req_pixel_y;
   logic [7:0]        req_entry_index;
   logic [7:0]        req_entry_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [7:0]        rsp_pixel_value;
   logic signed [15:0] rsp_noise_value;
   logic              csr_wr_en;
   logic [15:0]       csr_wr_data;

   int err_count, pending, pixels_checked, table_writes;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int quiet_cycles = 0;

   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE      = 20;

   perlin_noise_pixel_generator_core u_top (.*);

   pnpg_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic send(logic kind, logic [11:0] px, logic [11:0] py,
                       logic [7:0] idx, logic [7:0] val);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_req_type    <= kind;
      req_pixel_x     <= px;
      req_pixel_y     <= py;
      req_entry_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pixel(logic [11:0] px, logic [11:0] py);
      send(REQ_EVAL, px, py, 8'($urandom), 8'($urandom));
   endtask

   task automatic set_scale(logic [15:0] s);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic corners();
      pixel(12'd0, 12'd0);
      pixel(12'hFFF, 12'hFFF);
      pixel(12'hFFF, 12'd0);
      pixel(12'd0, 12'hFFF);
      pixel(12'hAAA, 12'h555);
   endtask

   task automatic random_phase(int n);
      repeat (n) begin
         if ($urandom_range(9) == 0)
            send(REQ_WRITE, 12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom));
         else
            pixel(12'($urandom), 12'($urandom));
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_req_type    = REQ_EVAL;
      req_pixel_x     = '0;
      req_pixel_y     = '0;
      req_entry_index = '0;
      req_entry_value = '0;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // load every table entry before any pixel reads it
      for (int i = 0; i < TABLE_SIZE; i++)
         send(REQ_WRITE, 12'($urandom), 12'($urandom), i[7:0],
              (i == 0) ? 8'hFF : 8'($urandom));
      send(REQ_WRITE, 12'hFFF, 12'hFFF, 8'hFF, 8'h00);
      corners();
      set_scale(16'hFFFF);
      corners();
      set_scale(16'h0000);
      corners();
      set_scale(16'h1000);
      corners();

      set_scale(16'($urandom));
      snd_idle_pct = 20;
      rcv_idle_pct = 49;
      random_phase(55);
      set_scale(16'($urandom));
      snd_idle_pct = 49;
      rcv_idle_pct = 20;
      random_phase(55);
      set_scale(SCALE_RESET);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      random_phase(55);

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("run: %0d pixels checked, %0d table writes, scales 410/max/0/1.0/random",
               pixels_checked, table_writes);
      if (err_count == 0 && pending == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
